FILE: hdl/cst_pkg.sv
// Package with token kinds, scan modes and character tables for the tokenizer.
package cst_pkg;

  localparam int KIND_BITS = 6;
  localparam int PREFIX_BITS = 64;
  localparam int KEYWORDS = 8;

  typedef logic [KIND_BITS-1:0] kind_t;

  localparam kind_t K_END = 6'd0;
  localparam kind_t K_ID = 6'd1;
  localparam kind_t K_NUMBER = 6'd2;
  localparam kind_t K_PLUS = 6'd3;
  localparam kind_t K_MINUS = 6'd4;
  localparam kind_t K_MUL = 6'd5;
  localparam kind_t K_DIV = 6'd6;
  localparam kind_t K_MOD = 6'd7;
  localparam kind_t K_ASSIGN = 6'd8;
  localparam kind_t K_SEMI = 6'd9;
  localparam kind_t K_COMMA = 6'd10;
  localparam kind_t K_LPAREN = 6'd11;
  localparam kind_t K_RPAREN = 6'd12;
  localparam kind_t K_LBRACE = 6'd13;
  localparam kind_t K_RBRACE = 6'd14;
  localparam kind_t K_LT = 6'd15;
  localparam kind_t K_GT = 6'd16;
  localparam kind_t K_LE = 6'd17;
  localparam kind_t K_GE = 6'd18;
  localparam kind_t K_EQ = 6'd19;
  localparam kind_t K_NE = 6'd20;
  localparam kind_t K_LAND = 6'd21;
  localparam kind_t K_LOR = 6'd22;
  localparam kind_t K_LNOT = 6'd23;
  localparam kind_t K_KWBASE = 6'd24;
  localparam kind_t K_UNKNOWN = 6'd32;

  typedef enum logic [7:0] {
    M_IDLE   = 8'b0000_0001,
    M_IDENT  = 8'b0000_0010,
    M_NUMBER = 8'b0000_0100,
    M_SLASH  = 8'b0000_1000,
    M_LCOMM  = 8'b0001_0000,
    M_BCOMM  = 8'b0010_0000,
    M_BSTAR  = 8'b0100_0000,
    M_OPER   = 8'b1000_0000
  } mode_t;

  typedef enum logic [2:0] {
    OP_NOT  = 3'd0,
    OP_EQ   = 3'd1,
    OP_LT   = 3'd2,
    OP_GT   = 3'd3,
    OP_AND  = 3'd4,
    OP_OR   = 3'd5
  } oper_t;

  // Keyword text with the first character in the lowest byte.
  localparam logic [PREFIX_BITS-1:0] KW_TEXT [KEYWORDS] = '{
    64'h0000_0000_0074_6e69,
    64'h0000_0000_6469_6f76,
    64'h0000_0000_0000_6669,
    64'h0000_0000_6573_6c65,
    64'h0000_0065_6c69_6877,
    64'h0000_006b_6165_7262,
    64'h6575_6e69_746e_6f63,
    64'h0000_6e72_7574_6572
  };
  localparam logic [3:0] KW_LEN [KEYWORDS] = '{
    4'd3, 4'd4, 4'd2, 4'd4, 4'd5, 4'd5, 4'd8, 4'd6
  };

  function automatic logic is_space(input logic [7:0] b);
    return b inside {8'd32, [8'd9:8'd13]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return b inside {["a":"z"], ["A":"Z"], "_"};
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {["0":"9"]};
  endfunction

  // Word length is clipped to four bits; anything above eight never matches.
  function automatic kind_t word_kind(input logic [PREFIX_BITS-1:0] prefix,
                                      input logic [3:0] len);
    kind_t k;
    k = K_ID;
    for (int i = 0; i < KEYWORDS; i++) begin
      if (len == KW_LEN[i] && prefix == KW_TEXT[i]) begin
        k = K_KWBASE + kind_t'(i);
      end
    end
    return k;
  endfunction

  function automatic logic [7:0] op_second(input oper_t op);
    case (op)
      OP_AND:  return "&";
      OP_OR:   return "|";
      default: return "=";
    endcase
  endfunction

  function automatic kind_t op_double(input oper_t op);
    case (op)
      OP_NOT:  return K_NE;
      OP_EQ:   return K_EQ;
      OP_LT:   return K_LE;
      OP_GT:   return K_GE;
      OP_AND:  return K_LAND;
      OP_OR:   return K_LOR;
      default: return K_NE;
    endcase
  endfunction

  function automatic kind_t op_single(input oper_t op);
    case (op)
      OP_NOT:  return K_LNOT;
      OP_EQ:   return K_ASSIGN;
      OP_LT:   return K_LT;
      OP_GT:   return K_GT;
      default: return K_UNKNOWN;
    endcase
  endfunction

  function automatic kind_t single_kind(input logic [7:0] b);
    case (b)
      "+":     return K_PLUS;
      "-":     return K_MINUS;
      "*":     return K_MUL;
      "%":     return K_MOD;
      ";":     return K_SEMI;
      ",":     return K_COMMA;
      "(":     return K_LPAREN;
      ")":     return K_RPAREN;
      "{":     return K_LBRACE;
      "}":     return K_RBRACE;
      default: return K_UNKNOWN;
    endcase
  endfunction

endpackage

FILE: hdl/c_subset_tokenizer.sv
// A token is written into the output queue when its byte is accepted and is offered from there.
// Throughput: one byte per cycle; a byte that causes two tokens is absorbed by a four-entry token queue,
// so input stalls only when three or more tokens are waiting.
// Reset: the scanner returns to idle with line 1, offset 0, and the token queue empties.
// An end-of-text transaction restores the same scanner state after emitting END.
// Top level of the C subset tokenizer: byte scanner and token output queue.
module c_subset_tokenizer #(
  parameter int LINE_BITS = 16,
  parameter int OFFSET_BITS = 24,
  parameter int LENGTH_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             text_byte,
  input  logic                   end_of_text,
  output logic                   out_valid,
  input  logic                   out_ready,
  output cst_pkg::kind_t         token_kind,
  output logic [LINE_BITS-1:0]   start_line,
  output logic [OFFSET_BITS-1:0] start_offset,
  output logic [LENGTH_BITS-1:0] token_length,
  output logic                   last_of_run
);

  import cst_pkg::*;

  localparam int TOK_BITS = KIND_BITS + LINE_BITS + OFFSET_BITS + LENGTH_BITS + 1;

  mode_t scan_mode;
  mode_t scan_mode_next;
  oper_t pending_operator;
  oper_t pending_operator_next;
  logic [PREFIX_BITS-1:0] word_prefix;
  logic [PREFIX_BITS-1:0] word_prefix_next;
  logic [LENGTH_BITS-1:0] run_length;
  logic [LENGTH_BITS-1:0] run_length_next;
  logic [LINE_BITS-1:0] line_count;
  logic [LINE_BITS-1:0] line_count_next;
  logic [OFFSET_BITS-1:0] byte_position;
  logic [OFFSET_BITS-1:0] byte_position_next;
  logic [LINE_BITS-1:0] token_start_line;
  logic [LINE_BITS-1:0] token_start_line_next;
  logic [OFFSET_BITS-1:0] token_start_position;
  logic [OFFSET_BITS-1:0] token_start_position_next;

  logic accept;
  logic queue_room;

  // Start of a token at the current byte.
  logic st_space;
  logic st_emit;
  kind_t st_kind;
  mode_t st_mode;
  oper_t st_oper;
  logic st_ident;
  logic st_digit;

  // Pending token and the token caused by the current byte.
  kind_t pend_kind;
  logic [LENGTH_BITS-1:0] pend_len;
  logic [3:0] run_short;
  logic a_valid;
  logic b_valid;
  kind_t b_kind;
  logic [LENGTH_BITS-1:0] b_len;

  logic push0;
  logic push1;
  logic [TOK_BITS-1:0] tok_a;
  logic [TOK_BITS-1:0] tok_b;
  logic [TOK_BITS-1:0] data0;
  logic [TOK_BITS-1:0] data1;
  logic [TOK_BITS-1:0] out_data;

  assign in_ready = queue_room;
  assign accept = in_valid & in_ready;

  always_comb begin
    st_space = is_space(text_byte);
    st_emit = 1'b0;
    st_kind = single_kind(text_byte);
    st_mode = M_IDLE;
    st_oper = OP_NOT;
    st_ident = 1'b0;
    st_digit = 1'b0;
    if (!st_space) begin
      if (text_byte == "/") begin
        st_mode = M_SLASH;
      end else if (is_alpha(text_byte)) begin
        st_mode = M_IDENT;
        st_ident = 1'b1;
      end else if (is_digit(text_byte)) begin
        st_mode = M_NUMBER;
        st_digit = 1'b1;
      end else begin
        case (text_byte)
          "!": begin
            st_mode = M_OPER;
            st_oper = OP_NOT;
          end
          "=": begin
            st_mode = M_OPER;
            st_oper = OP_EQ;
          end
          "<": begin
            st_mode = M_OPER;
            st_oper = OP_LT;
          end
          ">": begin
            st_mode = M_OPER;
            st_oper = OP_GT;
          end
          "&": begin
            st_mode = M_OPER;
            st_oper = OP_AND;
          end
          "|": begin
            st_mode = M_OPER;
            st_oper = OP_OR;
          end
          default: begin
            st_emit = 1'b1;
          end
        endcase
      end
    end
  end

  always_comb begin
    run_short = (run_length <= LENGTH_BITS'(8)) ? run_length[3:0] : 4'hF;
    case (scan_mode)
      M_IDENT: begin
        pend_kind = word_kind(word_prefix, run_short);
        pend_len = run_length;
      end
      M_NUMBER: begin
        pend_kind = K_NUMBER;
        pend_len = run_length;
      end
      M_SLASH: begin
        pend_kind = K_DIV;
        pend_len = LENGTH_BITS'(1);
      end
      default: begin
        pend_kind = op_single(pending_operator);
        pend_len = LENGTH_BITS'(1);
      end
    endcase
  end

  always_comb begin
    logic start;
    start = 1'b0;
    scan_mode_next = scan_mode;
    pending_operator_next = pending_operator;
    word_prefix_next = word_prefix;
    run_length_next = run_length;
    line_count_next = line_count;
    byte_position_next = byte_position;
    token_start_line_next = token_start_line;
    token_start_position_next = token_start_position;
    a_valid = 1'b0;
    b_valid = 1'b0;
    b_kind = st_kind;
    b_len = LENGTH_BITS'(1);

    if (end_of_text) begin
      a_valid = (scan_mode == M_IDENT) || (scan_mode == M_NUMBER) ||
                (scan_mode == M_SLASH) || (scan_mode == M_OPER);
      b_valid = 1'b1;
      b_kind = K_END;
      b_len = '0;
      scan_mode_next = M_IDLE;
      pending_operator_next = OP_NOT;
      word_prefix_next = '0;
      run_length_next = '0;
      line_count_next = LINE_BITS'(1);
      byte_position_next = '0;
      token_start_line_next = LINE_BITS'(1);
      token_start_position_next = '0;
    end else begin
      case (scan_mode)
        M_IDENT: begin
          if (is_alpha(text_byte) || is_digit(text_byte)) begin
            if (run_length < LENGTH_BITS'(8)) begin
              word_prefix_next[run_length[2:0]*8 +: 8] = text_byte;
            end
            if (run_length != '1) begin
              run_length_next = run_length + LENGTH_BITS'(1);
            end
          end else begin
            a_valid = 1'b1;
            start = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit(text_byte)) begin
            if (run_length != '1) begin
              run_length_next = run_length + LENGTH_BITS'(1);
            end
          end else begin
            a_valid = 1'b1;
            start = 1'b1;
          end
        end
        M_SLASH: begin
          if (text_byte == "/") begin
            scan_mode_next = M_LCOMM;
          end else if (text_byte == "*") begin
            scan_mode_next = M_BCOMM;
          end else begin
            a_valid = 1'b1;
            start = 1'b1;
          end
        end
        M_LCOMM: begin
          if (text_byte == 8'h0A) begin
            scan_mode_next = M_IDLE;
          end
        end
        M_BCOMM: begin
          if (text_byte == "*") begin
            scan_mode_next = M_BSTAR;
          end
        end
        M_BSTAR: begin
          if (text_byte == "/") begin
            scan_mode_next = M_IDLE;
          end else if (text_byte != "*") begin
            scan_mode_next = M_BCOMM;
          end
        end
        M_OPER: begin
          a_valid = 1'b1;
          if (text_byte == op_second(pending_operator)) begin
            scan_mode_next = M_IDLE;
          end else begin
            start = 1'b1;
          end
        end
        default: begin
          start = 1'b1;
        end
      endcase

      if (start) begin
        scan_mode_next = M_IDLE;
        if (!st_space) begin
          token_start_line_next = line_count;
          token_start_position_next = byte_position;
          scan_mode_next = st_mode;
          b_valid = st_emit;
          if (st_ident) begin
            word_prefix_next = PREFIX_BITS'(text_byte);
            run_length_next = LENGTH_BITS'(1);
          end
          if (st_digit) begin
            run_length_next = LENGTH_BITS'(1);
          end
          if (st_mode == M_OPER) begin
            pending_operator_next = st_oper;
          end
        end
      end

      if (text_byte == 8'h0A && line_count != '1) begin
        line_count_next = line_count + LINE_BITS'(1);
      end
      if (byte_position != '1) begin
        byte_position_next = byte_position + OFFSET_BITS'(1);
      end
    end
  end

  always_comb begin
    logic [LENGTH_BITS-1:0] a_len;
    kind_t a_kind;
    a_kind = pend_kind;
    a_len = pend_len;
    if (!end_of_text && scan_mode == M_OPER &&
        text_byte == op_second(pending_operator)) begin
      a_kind = op_double(pending_operator);
      a_len = LENGTH_BITS'(2);
    end
    tok_a = {a_kind, token_start_line, token_start_position, a_len, !b_valid};
    tok_b = {b_kind, line_count, byte_position, b_len, 1'b1};
    data0 = a_valid ? tok_a : tok_b;
    data1 = tok_b;
    push0 = accept & (a_valid | b_valid);
    push1 = accept & a_valid & b_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= M_IDLE;
      pending_operator <= OP_NOT;
      word_prefix <= '0;
      run_length <= '0;
      line_count <= LINE_BITS'(1);
      byte_position <= '0;
      token_start_line <= LINE_BITS'(1);
      token_start_position <= '0;
    end else if (accept) begin
      scan_mode <= scan_mode_next;
      pending_operator <= pending_operator_next;
      word_prefix <= word_prefix_next;
      run_length <= run_length_next;
      line_count <= line_count_next;
      byte_position <= byte_position_next;
      token_start_line <= token_start_line_next;
      token_start_position <= token_start_position_next;
    end
  end

  cst_result_queue #(
    .WIDTH(TOK_BITS)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push0(push0),
    .push1(push1),
    .data0(data0),
    .data1(data1),
    .room(queue_room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  assign {token_kind, start_line, start_offset, token_length, last_of_run} = out_data;

endmodule

FILE: hdl/cst_result_queue.sv
// Four-entry token queue that takes up to two entries and gives one per cycle while out_ready is high.
module cst_result_queue #(
  parameter int WIDTH = 80
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push0,
  input  logic             push1,
  input  logic [WIDTH-1:0] data0,
  input  logic [WIDTH-1:0] data1,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int DEPTH = 4;
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] count_next;
  logic pop;

  assign pop = out_valid & out_ready;
  assign out_valid = (count != '0);
  assign out_data = mem[rd_ptr];
  assign room = (count <= CNT_BITS'(DEPTH - 2));

  always_comb begin
    count_next = count + CNT_BITS'(push0) + CNT_BITS'(push1) - CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr] <= data0;
    end
    if (push1) begin
      mem[wr_ptr + PTR_BITS'(1)] <= data1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push0) + PTR_BITS'(push1);
      rd_ptr <= rd_ptr + PTR_BITS'(pop);
      count <= count_next;
    end
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the C subset tokenizer, with a scoreboard that predicts its tokens.
module tb_top;
  import cst_pkg::*;

  localparam int LINE_W = 16;
  localparam int OFF_W = 24;
  localparam int LEN_W = 16;
  localparam int PHASE_ITEMS = 240;
  localparam int LONG_RUN = 40;

  typedef struct {
    kind_t kind;
    logic [LINE_W-1:0] line;
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
    logic last;
  } token_t;

  class token_scoreboard;
    token_t expected_tokens[$];
    token_t burst[$];
    string keywords[8];
    int checked;
    int bad_count;
    mode_t mode;
    oper_t pend_op;
    logic [63:0] prefix;
    logic [LEN_W-1:0] run_len;
    logic [LINE_W-1:0] line_no;
    logic [OFF_W-1:0] pos;
    logic [LINE_W-1:0] tok_line;
    logic [OFF_W-1:0] tok_pos;

    function new();
      keywords = '{"int", "void", "if", "else", "while", "break", "continue", "return"};
      checked = 0;
      bad_count = 0;
      restart();
    endfunction

    function void restart();
      mode = M_IDLE;
      pend_op = OP_NOT;
      prefix = '0;
      run_len = '0;
      line_no = LINE_W'(1);
      pos = '0;
      tok_line = LINE_W'(1);
      tok_pos = '0;
    endfunction

    function bit letter(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function bit digit(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function logic [7:0] second_of(oper_t op);
      case (op)
        OP_AND: return "&";
        OP_OR: return "|";
        default: return "=";
      endcase
    endfunction

    function kind_t double_of(oper_t op);
      case (op)
        OP_NOT: return K_NE;
        OP_EQ: return K_EQ;
        OP_LT: return K_LE;
        OP_GT: return K_GE;
        OP_AND: return K_LAND;
        default: return K_LOR;
      endcase
    endfunction

    function kind_t single_of(oper_t op);
      case (op)
        OP_NOT: return K_LNOT;
        OP_EQ: return K_ASSIGN;
        OP_LT: return K_LT;
        OP_GT: return K_GT;
        default: return K_UNKNOWN;
      endcase
    endfunction

    function kind_t word_kind();
      kind_t k;
      bit same;
      k = K_ID;
      for (int i = 0; i < 8; i++) begin
        if (run_len == keywords[i].len()) begin
          same = 1'b1;
          for (int j = 0; j < keywords[i].len(); j++) begin
            if (prefix[8*j +: 8] != keywords[i][j]) same = 1'b0;
          end
          if (same) k = K_KWBASE + kind_t'(i);
        end
      end
      return k;
    endfunction

    function void add_token(kind_t k, logic [LINE_W-1:0] l, logic [OFF_W-1:0] o,
                            logic [LEN_W-1:0] n);
      token_t t;
      t.kind = k;
      t.line = l;
      t.offset = o;
      t.length = n;
      t.last = 1'b0;
      burst.insert(burst.size(), t);
    endfunction

    function void flush_pending(kind_t k, logic [LEN_W-1:0] n);
      add_token(k, tok_line, tok_pos, n);
      mode = M_IDLE;
    endfunction

    function void start_byte(logic [7:0] b);
      if (b == 8'd32 || (b >= 8'd9 && b <= 8'd13)) return;
      tok_line = line_no;
      tok_pos = pos;
      if (b == "/") begin
        mode = M_SLASH;
      end else if (letter(b)) begin
        mode = M_IDENT;
        prefix = {56'd0, b};
        run_len = LEN_W'(1);
      end else if (digit(b)) begin
        mode = M_NUMBER;
        run_len = LEN_W'(1);
      end else begin
        case (b)
          "!": begin mode = M_OPER; pend_op = OP_NOT; end
          "=": begin mode = M_OPER; pend_op = OP_EQ; end
          "<": begin mode = M_OPER; pend_op = OP_LT; end
          ">": begin mode = M_OPER; pend_op = OP_GT; end
          "&": begin mode = M_OPER; pend_op = OP_AND; end
          "|": begin mode = M_OPER; pend_op = OP_OR; end
          "+": add_token(K_PLUS, line_no, pos, LEN_W'(1));
          "-": add_token(K_MINUS, line_no, pos, LEN_W'(1));
          "*": add_token(K_MUL, line_no, pos, LEN_W'(1));
          "%": add_token(K_MOD, line_no, pos, LEN_W'(1));
          ";": add_token(K_SEMI, line_no, pos, LEN_W'(1));
          ",": add_token(K_COMMA, line_no, pos, LEN_W'(1));
          "(": add_token(K_LPAREN, line_no, pos, LEN_W'(1));
          ")": add_token(K_RPAREN, line_no, pos, LEN_W'(1));
          "{": add_token(K_LBRACE, line_no, pos, LEN_W'(1));
          "}": add_token(K_RBRACE, line_no, pos, LEN_W'(1));
          default: add_token(K_UNKNOWN, line_no, pos, LEN_W'(1));
        endcase
      end
    endfunction

    function void scan_byte(logic [7:0] b, logic eot);
      burst.delete();
      if (eot) begin
        case (mode)
          M_IDENT: flush_pending(word_kind(), run_len);
          M_NUMBER: flush_pending(K_NUMBER, run_len);
          M_SLASH: flush_pending(K_DIV, LEN_W'(1));
          M_OPER: flush_pending(single_of(pend_op), LEN_W'(1));
          default: ;
        endcase
        add_token(K_END, line_no, pos, '0);
        restart();
      end else begin
        case (mode)
          M_IDENT: begin
            if (letter(b) || digit(b)) begin
              if (run_len < 8) prefix[8*run_len +: 8] = b;
              if (run_len != '1) run_len = run_len + 1'b1;
            end else begin
              flush_pending(word_kind(), run_len);
              start_byte(b);
            end
          end
          M_NUMBER: begin
            if (digit(b)) begin
              if (run_len != '1) run_len = run_len + 1'b1;
            end else begin
              flush_pending(K_NUMBER, run_len);
              start_byte(b);
            end
          end
          M_SLASH: begin
            if (b == "/") begin
              mode = M_LCOMM;
            end else if (b == "*") begin
              mode = M_BCOMM;
            end else begin
              flush_pending(K_DIV, LEN_W'(1));
              start_byte(b);
            end
          end
          M_LCOMM: begin
            if (b == "\n") mode = M_IDLE;
          end
          M_BCOMM: begin
            if (b == "*") mode = M_BSTAR;
          end
          M_BSTAR: begin
            if (b == "/") begin
              mode = M_IDLE;
            end else if (b != "*") begin
              mode = M_BCOMM;
            end
          end
          M_OPER: begin
            if (b == second_of(pend_op)) begin
              flush_pending(double_of(pend_op), LEN_W'(2));
            end else begin
              flush_pending(single_of(pend_op), LEN_W'(1));
              start_byte(b);
            end
          end
          default: begin
            mode = M_IDLE;
            start_byte(b);
          end
        endcase
        if (b == "\n" && line_no != '1) line_no = line_no + 1'b1;
        if (pos != '1) pos = pos + 1'b1;
      end
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) expected_tokens.insert(expected_tokens.size(), burst[i]);
    endfunction

    function void check_token(token_t got);
      token_t want;
      if (expected_tokens.size() == 0) begin
        bad_count++;
        if (bad_count <= 10) begin
          $display("ERROR: unexpected token kind %0d line %0d offset %0d length %0d last %0b",
                   got.kind, got.line, got.offset, got.length, got.last);
        end
        return;
      end
      want = expected_tokens.pop_front();
      checked++;
      if (want.kind !== got.kind || want.line !== got.line || want.offset !== got.offset ||
          want.length !== got.length || want.last !== got.last) begin
        bad_count++;
        if (bad_count <= 10) begin
          $display("ERROR: token %0d expected kind %0d line %0d offset %0d length %0d last %0b",
                   checked, want.kind, want.line, want.offset, want.length, want.last);
          $display("ERROR: token %0d actual   kind %0d line %0d offset %0d length %0d last %0b",
                   checked, got.kind, got.line, got.offset, got.length, got.last);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [7:0] text_byte = 8'd0;
  logic end_of_text = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  kind_t token_kind;
  logic [LINE_W-1:0] start_line;
  logic [OFF_W-1:0] start_offset;
  logic [LEN_W-1:0] token_length;
  logic last_of_run;

  token_scoreboard lexer_sb = new();
  int bytes_sent = 0;
  int ends_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int send_idle_by_phase[4] = '{0, 53, 0, 22};
  int recv_stall_by_phase[4] = '{0, 0, 53, 22};
  string operators[23] = '{"+", "-", "*", "/", "%", ";", ",", "(", ")", "{", "}", "<", ">",
                           "<=", ">=", "==", "!=", "&&", "||", "!", "=", "&", "|"};
  logic [7:0] blanks[6] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};

  c_subset_tokenizer #(
    .LINE_BITS(LINE_W),
    .OFFSET_BITS(OFF_W),
    .LENGTH_BITS(LEN_W)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .text_byte(text_byte),
    .end_of_text(end_of_text),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .token_kind(token_kind),
    .start_line(start_line),
    .start_offset(start_offset),
    .token_length(token_length),
    .last_of_run(last_of_run)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    token_t got;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.kind = token_kind;
        got.line = start_line;
        got.offset = start_offset;
        got.length = token_length;
        got.last = last_of_run;
        lexer_sb.check_token(got);
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(logic [7:0] b, logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    end_of_text <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lexer_sb.scan_byte(b, eot);
    bytes_sent++;
    if (eot) ends_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (lexer_sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] rand_alnum();
    if ($urandom_range(4) == 0) return 8'("0" + $urandom_range(9));
    return rand_letter();
  endfunction

  function automatic logic [7:0] comment_byte();
    case ($urandom_range(4))
      0: return "*";
      1: return "/";
      2: return "\n";
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random_piece();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 12) begin
      send_text(lexer_sb.keywords[$urandom_range(7)]);
      if ($urandom_range(9) == 0) send_item(rand_alnum(), 1'b0);
    end else if (pick < 26) begin
      n = ($urandom_range(7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
      send_item(rand_letter(), 1'b0);
      repeat (n - 1) send_item(rand_alnum(), 1'b0);
    end else if (pick < 34) begin
      repeat ($urandom_range(1, 5)) send_item(8'("0" + $urandom_range(9)), 1'b0);
    end else if (pick < 56) begin
      send_text(operators[$urandom_range(22)]);
    end else if (pick < 70) begin
      send_item(blanks[$urandom_range(5)], 1'b0);
    end else if (pick < 77) begin
      send_text("//");
      repeat ($urandom_range(0, 6)) send_item(8'($urandom_range(32, 126)), 1'b0);
      if ($urandom_range(9) != 0) send_item("\n", 1'b0);
    end else if (pick < 85) begin
      send_text("/*");
      repeat ($urandom_range(0, 6)) send_item(comment_byte(), 1'b0);
      if ($urandom_range(6) != 0) send_text("*/");
    end else if (pick < 97) begin
      send_item(8'($urandom_range(255)), 1'b0);
    end else begin
      send_item(8'($urandom_range(255)), 1'b1);
    end
    if ($urandom_range(9) < 4) send_item(" ", 1'b0);
  endtask

  initial begin
    int phase_start;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_text("\nint x&y|=<=!/*c*/9");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h5A, 1'b1);
    send_text("a/");
    send_item(8'h00, 1'b1);
    send_text("/*");
    send_item(8'hA5, 1'b1);
    send_text("<");
    send_item(8'hFF, 1'b1);
    wait_drained();

    hold_left = 400;
    repeat (60) send_item(";", 1'b0);
    wait_drained();

    repeat (LONG_RUN) send_item("\n", 1'b0);
    send_text("a ");
    send_item(8'h00, 1'b1);
    send_text("continue");
    repeat (LONG_RUN) send_item("x", 1'b0);
    send_text(" 1");
    repeat (LONG_RUN) send_item("7", 1'b0);
    send_item(8'h00, 1'b1);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_idle_by_phase[ph];
      recv_stall_pct = recv_stall_by_phase[ph];
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_ITEMS) send_random_piece();
      send_item(8'($urandom_range(255)), 1'b1);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d bytes and %0d end-of-text marks under four idle and stall mixes,",
             bytes_sent, ends_sent);
    $display("a long receiver hold-off and long lines, words and numbers; %0d tokens checked.",
             lexer_sb.checked);
    if (lexer_sb.bad_count == 0 && lexer_sb.expected_tokens.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
